// ----- hdl/ami_pkg.sv -----
// ---------------------------------------------------------------------------
// ami_pkg
// Shared types and constants for the abs-max index finder.
// ---------------------------------------------------------------------------
package ami_pkg;

  localparam int DATA_W     = 32;              // Q16.16 element parts
  localparam int IDX_W      = 16;              // element position
  localparam int SQ_W       = 2 * DATA_W;      // squared magnitude
  localparam int ROOT_STEPS = SQ_W / 2;        // one root bit per step
  localparam int STEP_W     = $clog2(ROOT_STEPS);
  localparam int REM_W      = DATA_W + 2;      // square root remainder
  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 3;

  // register index (byte address / 4)
  localparam logic [CFG_ADDR_W-3:0] REG_COMPLEX_MODE = '0;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_SQRE = 6'b000010,
    S_SQIM = 6'b000100,
    S_CMP  = 6'b001000,
    S_SQRT = 6'b010000,
    S_DONE = 6'b100000
  } ami_state_t;

  typedef struct packed {
    logic load_in;
    logic sq_re;
    logic sq_im;
    logic cmp;
    logic sqrt_step;
    logic out_load;
  } ami_cmd_t;

  typedef struct packed {
    logic last;
    logic sqrt_last;
  } ami_stat_t;

endpackage

// ----- hdl/ami_if.sv -----
// ---------------------------------------------------------------------------
// ami_in_if / ami_out_if
// Valid/ready channels for vector elements and results.
// ---------------------------------------------------------------------------
interface ami_in_if;
  import ami_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] real_part;
  logic signed [DATA_W-1:0] imag_part;
  logic                     last;

  modport source (output valid, real_part, imag_part, last, input ready);
  modport sink   (input valid, real_part, imag_part, last, output ready);
endinterface

interface ami_out_if;
  import ami_pkg::*;

  logic              valid;
  logic              ready;
  logic [IDX_W-1:0]  max_index;
  logic [DATA_W-1:0] max_magnitude;

  modport source (output valid, max_index, max_magnitude, input ready);
  modport sink   (input valid, max_index, max_magnitude, output ready);
endinterface

// ----- hdl/abs_max_index_finder.sv -----
// ---------------------------------------------------------------------------
// abs_max_index_finder
// Streaming index and value of the largest magnitude in a vector.
// ---------------------------------------------------------------------------
// Elements arrive on in_ch, one transfer each, real or complex per the
// complex_mode register (APB, byte address 0). The running best holds the
// largest squared magnitude and the first position where it occurred.
// The element flagged last closes the vector: its result (index, floored
// root of the best square) appears on out_ch and the running state clears.
// Elements do not overlap: in_ch.ready stays low while the shared 32x32
// squarer takes the real square, then the imaginary square, and the two
// are added and compared. After the last element, the 32-step square root
// and the handoff state run in turn before out_ch.valid rises.
// The result sits in an output register, so a new vector streams in while
// it waits; if the next result finishes first, the block holds in that
// state (in_ch.ready low) until out_ch drains.
// Reset (rst_n, synchronous) clears the running state, drops out_ch.valid
// and sets complex_mode to real.
// ---------------------------------------------------------------------------
module abs_max_index_finder (
  input  logic                               clk,
  input  logic                               rst_n,
  ami_in_if.sink                             in_ch,
  ami_out_if.source                          out_ch,
  input  logic                               cfg_psel,
  input  logic                               cfg_penable,
  input  logic                               cfg_pwrite,
  input  logic [ami_pkg::CFG_ADDR_W-1:0]     cfg_paddr,
  input  logic [ami_pkg::CFG_DATA_W-1:0]     cfg_pwdata,
  output logic [ami_pkg::CFG_DATA_W-1:0]     cfg_prdata,
  output logic                               cfg_pready
);
  import ami_pkg::*;

  logic      complex_mode_r, complex_mode_nxt;
  logic      cfg_hit;
  ami_cmd_t  cmd;
  ami_stat_t stat;

  assign cfg_hit    = (cfg_paddr[CFG_ADDR_W-1:2] == REG_COMPLEX_MODE);
  assign cfg_pready = 1'b1;
  assign cfg_prdata = cfg_hit ? CFG_DATA_W'(complex_mode_r) : '0;

  always_comb begin
    complex_mode_nxt = complex_mode_r;
    if (cfg_psel && cfg_penable && cfg_pwrite && cfg_hit) begin
      complex_mode_nxt = cfg_pwdata[0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      complex_mode_r <= 1'b0;
    end else begin
      complex_mode_r <= complex_mode_nxt;
    end
  end

  ami_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  ami_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .complex_mode  (complex_mode_r),
    .real_part     (in_ch.real_part),
    .imag_part     (in_ch.imag_part),
    .last          (in_ch.last),
    .stat          (stat),
    .max_index     (out_ch.max_index),
    .max_magnitude (out_ch.max_magnitude)
  );

endmodule

// ----- hdl/ami_ctrl.sv -----
// ---------------------------------------------------------------------------
// ami_ctrl
// Sequencer: squares, compare, square root and result handoff.
// ---------------------------------------------------------------------------
module ami_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  ami_pkg::ami_stat_t stat,
  output ami_pkg::ami_cmd_t  cmd
);
  import ami_pkg::*;

  ami_state_t state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        cmd.load_in = in_valid;
        if (in_valid) state_nxt = S_SQRE;
      end
      S_SQRE: begin
        cmd.sq_re = 1'b1;
        state_nxt = S_SQIM;
      end
      S_SQIM: begin
        cmd.sq_im = 1'b1;
        state_nxt = S_CMP;
      end
      S_CMP: begin
        cmd.cmp   = 1'b1;
        state_nxt = stat.last ? S_SQRT : S_IDLE;
      end
      S_SQRT: begin
        cmd.sqrt_step = 1'b1;
        if (stat.sqrt_last) state_nxt = S_DONE;
      end
      S_DONE: begin
        // output register must be free or draining this cycle
        if (!out_valid_r || out_ready) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

endmodule

// ----- hdl/ami_dp.sv -----
// ---------------------------------------------------------------------------
// ami_dp
// Datapath: abs values, shared squarer, running best, iterative square root.
// ---------------------------------------------------------------------------
module ami_dp (
  input  logic                              clk,
  input  logic                              rst_n,
  input  ami_pkg::ami_cmd_t                 cmd,
  input  logic                              complex_mode,
  input  logic signed [ami_pkg::DATA_W-1:0] real_part,
  input  logic signed [ami_pkg::DATA_W-1:0] imag_part,
  input  logic                              last,
  output ami_pkg::ami_stat_t                stat,
  output logic [ami_pkg::IDX_W-1:0]         max_index,
  output logic [ami_pkg::DATA_W-1:0]        max_magnitude
);
  import ami_pkg::*;

  // element registers
  logic [DATA_W-1:0] a_re_r, a_im_r;
  logic              last_r, mode_r;
  logic [SQ_W-1:0]   sq_re_r, sq_im_r;
  // running best (reset state)
  logic [SQ_W-1:0]   best_r, best_nxt;
  logic [IDX_W-1:0]  pos_r, pos_nxt;
  logic [IDX_W-1:0]  cnt_r, cnt_nxt;
  // square root unit
  logic [SQ_W-1:0]   rad_r, rad_nxt;
  logic [DATA_W-1:0] root_r, root_nxt;
  logic [REM_W-1:0]  rem_r, rem_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [IDX_W-1:0]  idx_r;
  // result register
  logic [IDX_W-1:0]  max_index_r;
  logic [DATA_W-1:0] max_magnitude_r;

  logic [DATA_W-1:0] abs_re, abs_im, mul_op;
  logic [SQ_W-1:0]   prod, sum;
  logic              better;
  logic [SQ_W-1:0]   win_sq;
  logic [IDX_W-1:0]  win_pos;
  logic [REM_W+1:0]  rem_t, trial, diff;

  // two's complement magnitude; the most negative value maps to 2^31 unsigned
  assign abs_re = real_part[DATA_W-1] ? DATA_W'(-real_part) : DATA_W'(real_part);
  assign abs_im = imag_part[DATA_W-1] ? DATA_W'(-imag_part) : DATA_W'(imag_part);

  assign mul_op = cmd.sq_im ? a_im_r : a_re_r;
  assign prod   = SQ_W'(mul_op) * SQ_W'(mul_op);

  assign sum     = sq_re_r + sq_im_r;
  assign better  = (sum > best_r);
  assign win_sq  = better ? sum : best_r;
  assign win_pos = better ? cnt_r : pos_r;

  // restoring root: two radicand bits in, one root bit out per step
  assign rem_t = {rem_r, rad_r[SQ_W-1 -: 2]};
  assign trial = {2'b00, root_r, 2'b01};
  assign diff  = rem_t - trial;

  always_comb begin
    best_nxt = best_r;
    pos_nxt  = pos_r;
    cnt_nxt  = cnt_r;
    rad_nxt  = rad_r;
    root_nxt = root_r;
    rem_nxt  = rem_r;
    step_nxt = step_r;
    if (cmd.cmp) begin
      if (last_r) begin
        best_nxt = '0;
        pos_nxt  = '0;
        cnt_nxt  = '0;
        rad_nxt  = win_sq;
        root_nxt = '0;
        rem_nxt  = '0;
        step_nxt = '0;
      end else begin
        best_nxt = win_sq;
        pos_nxt  = win_pos;
        cnt_nxt  = cnt_r + IDX_W'(1);   // wraps at 2^16
      end
    end else if (cmd.sqrt_step) begin
      rad_nxt  = {rad_r[SQ_W-3:0], 2'b00};
      step_nxt = step_r + STEP_W'(1);
      if (rem_t >= trial) begin
        rem_nxt  = diff[REM_W-1:0];
        root_nxt = {root_r[DATA_W-2:0], 1'b1};
      end else begin
        rem_nxt  = rem_t[REM_W-1:0];
        root_nxt = {root_r[DATA_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      best_r <= '0;
      pos_r  <= '0;
      cnt_r  <= '0;
      step_r <= '0;
    end else begin
      best_r <= best_nxt;
      pos_r  <= pos_nxt;
      cnt_r  <= cnt_nxt;
      step_r <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rad_r  <= rad_nxt;
    root_r <= root_nxt;
    rem_r  <= rem_nxt;
    if (cmd.load_in) begin
      a_re_r <= abs_re;
      a_im_r <= abs_im;
      last_r <= last;
      mode_r <= complex_mode;
    end
    if (cmd.sq_re) sq_re_r <= prod;
    if (cmd.sq_im) sq_im_r <= mode_r ? prod : '0;
    if (cmd.cmp && last_r) idx_r <= win_pos;
    if (cmd.out_load) begin
      max_index_r     <= idx_r;
      max_magnitude_r <= root_r;
    end
  end

  assign stat.last      = last_r;
  assign stat.sqrt_last = (step_r == STEP_W'(ROOT_STEPS - 1));
  assign max_index      = max_index_r;
  assign max_magnitude  = max_magnitude_r;

endmodule

// ----- hdl/ami_checker.sv -----
// ---------------------------------------------------------------------------
// ami_checker
// Port-level checks for abs_max_index_finder, bound to the top level.
// ---------------------------------------------------------------------------
module ami_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [ami_pkg::IDX_W-1:0]   max_index,
  input logic [ami_pkg::DATA_W-1:0]  max_magnitude
);
  import ami_pkg::*;

  // each element keeps the sequencer busy: no transfer right after another
  a_in_spacing: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted on consecutive cycles");

  // a result never appears directly after an element transfer
  a_out_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> !$past(in_valid && in_ready))
    else $error("result raised right after an input transfer");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(max_index) && $stable(max_magnitude))
    else $error("result payload changed while stalled");

endmodule

bind abs_max_index_finder ami_checker u_ami_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_ch.valid),
  .in_ready      (in_ch.ready),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .max_index     (out_ch.max_index),
  .max_magnitude (out_ch.max_magnitude)
);

// ----- tb/tb_abs_max_index_finder.sv -----
// ---------------------------------------------------------------------------
// tb_abs_max_index_finder
// Self-checking bench for the streaming abs-max index finder.
// ---------------------------------------------------------------------------
// Vector elements go in over in_ch and results come back over out_ch. Both
// sides are throttled at random outside a calm stretch. A running-maximum
// model in the bench folds each accepted element and queues the index and
// magnitude it expects at each vector's close. The stimulus has two parts:
//   - a short table of corner cases, a few of them with hand-computed results;
//   - random vectors, with mode flips between phases and sometimes in the
//     middle of a vector.
// ---------------------------------------------------------------------------
module tb_abs_max_index_finder;
  import ami_pkg::*;

  localparam int MAX_LEN        = 65536;
  localparam int QUIESCE_CYCLES = 48;         // exceeds the result latency plus the squarer
  localparam int CYCLE_LIMIT    = 3_000_000;
  localparam int RANDOM_ITEMS   = 680;

  localparam logic MODE_REAL    = 1'b0;
  localparam logic MODE_COMPLEX = 1'b1;

  typedef struct packed {
    logic [IDX_W-1:0]  idx;
    logic [DATA_W-1:0] mag;
  } maximum_t;

  typedef struct packed {
    logic              mode;
    logic [DATA_W-1:0] re;
    logic [DATA_W-1:0] im;
    logic              last;
    logic              typed;    // result below is hand-computed
    maximum_t          result;
  } stim_row_t;

  localparam int DIR_COUNT = 22;
  localparam stim_row_t DIR_ROWS [DIR_COUNT] = '{
    // all-zero vector
    '{MODE_REAL,    32'h0000_0000, 32'h0000_0000, 1'b1, 1'b1, '{16'd0, 32'd0}},
    // tie keeps the earlier element, imaginary part ignored
    '{MODE_REAL,    32'h0000_0005, 32'h0000_0000, 1'b0, 1'b0, '{16'd0, 32'd0}},
    '{MODE_REAL,    32'hFFFF_FFFB, 32'h0000_0007, 1'b1, 1'b1, '{16'd0, 32'd5}},
    // most negative real
    '{MODE_REAL,    32'h8000_0000, 32'h7FFF_FFFF, 1'b1, 1'b1, '{16'd0, 32'h8000_0000}},
    '{MODE_REAL,    32'h7FFF_FFFF, 32'h8000_0000, 1'b0, 1'b0, '{16'd0, 32'd0}},
    '{MODE_REAL,    32'h8000_0000, 32'h0000_0000, 1'b1, 1'b1, '{16'd1, 32'h8000_0000}},
    // leading zeros
    '{MODE_REAL,    32'h0000_0000, 32'h0000_0000, 1'b0, 1'b0, '{16'd0, 32'd0}},
    '{MODE_REAL,    32'h0000_0000, 32'h0000_0000, 1'b0, 1'b0, '{16'd0, 32'd0}},
    '{MODE_REAL,    32'h0000_0003, 32'h0000_0000, 1'b1, 1'b1, '{16'd2, 32'd3}},
    '{MODE_REAL,    32'hFFFF_FFFF, 32'h0000_0000, 1'b1, 1'b1, '{16'd0, 32'd1}},
    // largest complex square, 2^63
    '{MODE_COMPLEX, 32'h8000_0000, 32'h8000_0000, 1'b1, 1'b1, '{16'd0, 32'd3037000499}},
    // 3-4-5 tie in complex mode
    '{MODE_COMPLEX, 32'h0000_0003, 32'h0000_0004, 1'b0, 1'b0, '{16'd0, 32'd0}},
    '{MODE_COMPLEX, 32'h0000_0000, 32'hFFFF_FFFB, 1'b1, 1'b1, '{16'd0, 32'd5}},
    '{MODE_COMPLEX, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1, 1'b0, '{16'd0, 32'd0}},
    '{MODE_COMPLEX, 32'h0000_0000, 32'h8000_0000, 1'b1, 1'b1, '{16'd0, 32'h8000_0000}},
    '{MODE_COMPLEX, 32'h1234_5678, 32'hEDCB_A987, 1'b0, 1'b0, '{16'd0, 32'd0}},
    '{MODE_COMPLEX, 32'h0001_0000, 32'hFFFF_0000, 1'b1, 1'b0, '{16'd0, 32'd0}},
    // mode flip inside a vector keeps the running best
    '{MODE_COMPLEX, 32'h0000_0001, 32'h0000_0001, 1'b0, 1'b0, '{16'd0, 32'd0}},
    '{MODE_REAL,    32'hFFFF_FFFF, 32'h0000_0064, 1'b0, 1'b0, '{16'd0, 32'd0}},
    '{MODE_REAL,    32'h0000_0002, 32'h0000_0000, 1'b1, 1'b1, '{16'd2, 32'd2}},
    '{MODE_REAL,    32'h5555_5555, 32'hAAAA_AAAA, 1'b0, 1'b0, '{16'd0, 32'd0}},
    '{MODE_REAL,    32'hAAAA_AAAA, 32'h5555_5555, 1'b1, 1'b0, '{16'd0, 32'd0}}
  };

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_psel;
  logic                  cfg_penable;
  logic                  cfg_pwrite;
  logic [CFG_ADDR_W-1:0] cfg_paddr;
  logic [CFG_DATA_W-1:0] cfg_pwdata;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  ami_in_if  in_ch ();
  ami_out_if out_ch ();

  abs_max_index_finder DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // running-maximum model
  logic         mode_now;
  logic [63:0]  best_sq;
  logic [15:0]  best_pos;
  int unsigned  elem_cnt;

  maximum_t     pending_maxima [$];
  int           fail_count = 0;
  int unsigned  cycle_count = 0;
  bit           calm = 1'b0;      // no idling on either side while set

  function automatic logic [32:0] magnitude33(input logic [DATA_W-1:0] v);
    if (v[DATA_W-1]) return 33'h1_0000_0000 - {1'b0, v};
    return {1'b0, v};
  endfunction

  function automatic logic [31:0] floor_sqrt64(input logic [63:0] x);
    logic [63:0] root;
    logic [63:0] trial;
    root = '0;
    for (int b = 31; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= x) root = trial;
    end
    return root[31:0];
  endfunction

  // fold one element into the running best; returns 1 when a vector closes
  function automatic bit fold_element(input logic [DATA_W-1:0] re,
                                      input logic [DATA_W-1:0] im,
                                      input logic last,
                                      output maximum_t res);
    logic [63:0] sq;
    logic [32:0] mr;
    logic [32:0] mi;
    mr = magnitude33(re);
    sq = 64'(mr) * 64'(mr);
    if (mode_now == MODE_COMPLEX) begin
      mi = magnitude33(im);
      sq = sq + 64'(mi) * 64'(mi);
    end
    if (sq > best_sq) begin
      best_sq  = sq;
      best_pos = elem_cnt[15:0];
    end
    elem_cnt = (elem_cnt + 1 >= MAX_LEN || elem_cnt + 1 > 32'hFFFF) ? 0 : elem_cnt + 1;
    res = '0;
    if (!last) return 1'b0;
    res.idx  = best_pos;
    res.mag  = floor_sqrt64(best_sq);
    best_sq  = '0;
    best_pos = '0;
    elem_cnt = 0;
    return 1'b1;
  endfunction

  function automatic logic [DATA_W-1:0] rand_part();
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'h0000_0000;
      3: return 32'($urandom_range(0, 255)) - 32'd128;
      4: return 32'($urandom_range(0, 65535)) << 16;
      default: return $urandom();
    endcase
  endfunction

  // one element transfer; called at a falling edge, returns at a falling edge
  task automatic put_element(input logic [DATA_W-1:0] re, input logic [DATA_W-1:0] im,
                             input logic last, input logic typed, input maximum_t typed_res);
    maximum_t res;
    while (!calm && $urandom_range(0, 99) < 10) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.real_part = re;
    in_ch.imag_part = im;
    in_ch.last      = last;
    in_ch.valid     = 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    if (fold_element(re, im, last, res))
      pending_maxima.push_back(typed ? typed_res : res);
    @(negedge clk);
  endtask

  // hold off until every result is out and the squarer has settled
  task automatic wait_drained();
    in_ch.valid = 1'b0;
    while (pending_maxima.size() != 0) @(negedge clk);
    repeat (QUIESCE_CYCLES) @(negedge clk);
  endtask

  task automatic write_mode(input logic mode);
    logic [CFG_DATA_W-1:0] wdata;
    wdata       = $urandom();
    wdata[0]    = mode;
    cfg_paddr   = {REG_COMPLEX_MODE, 2'b00};
    cfg_pwdata  = wdata;
    cfg_pwrite  = 1'b1;
    cfg_psel    = 1'b1;
    cfg_penable = 1'b0;
    @(negedge clk);
    cfg_penable = 1'b1;
    do @(posedge clk); while (!cfg_pready);
    mode_now = mode;
    @(negedge clk);
    // read back
    cfg_pwrite  = 1'b0;
    cfg_penable = 1'b0;
    @(negedge clk);
    cfg_penable = 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (cfg_prdata !== CFG_DATA_W'(mode)) begin
      $error("complex_mode readback mismatch: expected %0h, actual %0h", mode, cfg_prdata);
      fail_count++;
    end
    @(negedge clk);
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
  endtask

  // result receiver
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ch.ready = calm ? 1'b1 : ($urandom_range(0, 99) >= 10);
    end
  end

  always @(posedge clk) begin
    maximum_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_maxima.size() == 0) begin
        $error("unexpected result transfer: max_index %0d, max_magnitude %0d",
               out_ch.max_index, out_ch.max_magnitude);
        fail_count++;
      end else begin
        want = pending_maxima.pop_front();
        if (out_ch.max_index !== want.idx) begin
          $error("max_index mismatch: expected %0d, actual %0d", want.idx, out_ch.max_index);
          fail_count++;
        end
        if (out_ch.max_magnitude !== want.mag) begin
          $error("max_magnitude mismatch: expected %0d, actual %0d",
                 want.mag, out_ch.max_magnitude);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    logic [DATA_W-1:0] re;
    logic [DATA_W-1:0] im;
    logic [DATA_W-1:0] prev_re;
    logic [DATA_W-1:0] prev_im;
    int                sent;
    int                next_phase;
    int                vec_len;

    rst_n           = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.real_part = '0;
    in_ch.imag_part = '0;
    in_ch.last      = 1'b0;
    cfg_psel        = 1'b0;
    cfg_penable     = 1'b0;
    cfg_pwrite      = 1'b0;
    cfg_paddr       = '0;
    cfg_pwdata      = '0;
    mode_now        = MODE_REAL;
    best_sq         = '0;
    best_pos        = '0;
    elem_cnt        = 0;
    prev_re         = '0;
    prev_im         = '0;

    repeat (10) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);
    write_mode(MODE_REAL);

    for (int r = 0; r < DIR_COUNT; r++) begin
      if (DIR_ROWS[r].mode != mode_now) begin
        wait_drained();
        write_mode(DIR_ROWS[r].mode);
      end
      put_element(DIR_ROWS[r].re, DIR_ROWS[r].im, DIR_ROWS[r].last,
                  DIR_ROWS[r].typed, DIR_ROWS[r].result);
    end

    // random vectors; phase boundaries may fall mid-vector
    sent       = 0;
    next_phase = $urandom_range(60, 140);
    while (sent < RANDOM_ITEMS) begin
      vec_len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
      for (int k = 0; k < vec_len; k++) begin
        if (sent >= next_phase) begin
          wait_drained();
          write_mode(!mode_now);
          next_phase = sent + $urandom_range(60, 140);
        end
        calm = (sent >= 250 && sent < 400);
        if (k > 0 && $urandom_range(0, 9) == 0) begin
          // equal magnitude as the previous element
          re = $urandom_range(0, 1) ? -prev_re : prev_re;
          im = prev_im;
        end else begin
          re = rand_part();
          im = rand_part();
        end
        put_element(re, im, k == vec_len - 1, 1'b0, '0);
        prev_re = re;
        prev_im = im;
        sent++;
      end
    end
    calm = 1'b0;

    in_ch.valid = 1'b0;
    while (pending_maxima.size() != 0) @(negedge clk);
    repeat (QUIESCE_CYCLES) @(negedge clk);
    if (fail_count == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule

// ----- filelist.f -----
hdl/ami_pkg.sv
hdl/ami_if.sv
hdl/ami_ctrl.sv
hdl/ami_dp.sv
hdl/abs_max_index_finder.sv
hdl/ami_checker.sv
tb/tb_abs_max_index_finder.sv
